/* sv/seci_pkg.sv */
// ----------------------------------------------------------------------------
// seci_pkg: shared types and constants for the stage engine cutoff interlock
// Channel codes, latch bit positions, register indexes and the item and
// result records that travel between the front, queue and back sections.
// ----------------------------------------------------------------------------
package seci_pkg;

    localparam int unsigned MASS_W    = 19;
    localparam int unsigned CH_W      = 7;
    localparam int unsigned NUM_ENG   = 8;
    localparam int unsigned SW_W      = 24;
    localparam int unsigned LATCH_W   = 9;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 40;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPLETION  = 4'd1;

    localparam logic [MASS_W-1:0] LOW_LEVEL_RESET = 19'd24000;
    localparam logic [MASS_W-1:0] DEPLETION_RESET = 19'd4212;

    // Input kind carried on tuser
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    // Switch selector channels
    localparam logic [CH_W-1:0] CH_ME_ENABLE_2 = 7'd15;
    localparam logic [CH_W-1:0] CH_ME_ENABLE_1 = 7'd16;
    localparam logic [CH_W-1:0] CH_OB_CUTOFF   = 7'd18;
    localparam logic [CH_W-1:0] CH_SEPARATION  = 7'd23;
    localparam logic [CH_W-1:0] CH_FUEL_DEPL   = 7'd79;
    localparam logic [CH_W-1:0] CH_LOX_DEPL    = 7'd97;
    localparam logic [CH_W-1:0] CH_IB_CUTOFF   = 7'd98;
    localparam logic [CH_W-1:0] CH_SE_ENABLE   = 7'd100;
    localparam logic [CH_W-1:0] CH_LEVEL_EN    = 7'd104;

    // Latch bit positions
    localparam int unsigned LB_ME2   = 0;
    localparam int unsigned LB_ME1   = 1;
    localparam int unsigned LB_OBCUT = 2;
    localparam int unsigned LB_SEP   = 3;
    localparam int unsigned LB_FUEL  = 4;
    localparam int unsigned LB_LOX   = 5;
    localparam int unsigned LB_IBCUT = 6;
    localparam int unsigned LB_SE    = 7;
    localparam int unsigned LB_PLS   = 8;

    typedef logic [LATCH_W-1:0] t_latch;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic                is_cmd;
        t_latch              latch_set;
        logic [SW_W-1:0]     sw;
        logic                umb;
        logic                level_dry;
        logic                dep_trip;
    } t_item;

    // Result record, last member in the lowest bits
    typedef struct packed {
        logic                inboard_engine_out;
        logic                outboard_engine_out;
        logic                retro_fire;
        logic                separation_fire;
        logic                outboard_cutoff_flag;
        logic                low_level_dry;
        logic [SW_W-1:0]     thrust_ok_switches;
        logic [NUM_ENG-1:0]  cutoff_command_mask;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

    function automatic t_latch decode_channel(input logic [CH_W-1:0] ch);
        t_latch m;
        m = '0;
        case (ch)
            CH_ME_ENABLE_2: m[LB_ME2]   = 1'b1;
            CH_ME_ENABLE_1: m[LB_ME1]   = 1'b1;
            CH_OB_CUTOFF:   m[LB_OBCUT] = 1'b1;
            CH_SEPARATION:  m[LB_SEP]   = 1'b1;
            CH_FUEL_DEPL:   m[LB_FUEL]  = 1'b1;
            CH_LOX_DEPL:    m[LB_LOX]   = 1'b1;
            CH_IB_CUTOFF:   m[LB_IBCUT] = 1'b1;
            CH_SE_ENABLE:   m[LB_SE]    = 1'b1;
            CH_LEVEL_EN:    m[LB_PLS]   = 1'b1;
            default:        m = '0;
        endcase
        return m;
    endfunction

endpackage

/* sv/seci_front.sv */
// ----------------------------------------------------------------------------
// seci_front: input classification
// Holds the mass thresholds, decodes commands to latch masks and turns tick
// items into switch states and sensor trip bits.
// ----------------------------------------------------------------------------
module seci_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [seci_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [seci_pkg::MASS_W-1:0]       i_cfg_data,
    output logic                              o_cfg_ready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_req_type,
    input  logic [seci_pkg::CH_W-1:0]         i_selector_channel,
    input  logic [seci_pkg::NUM_ENG-1:0]      i_engine_thrust_ok,
    input  logic [seci_pkg::SW_W-1:0]         i_thrust_ok_simulate,
    input  logic                              i_umbilical_connected,
    input  logic [seci_pkg::MASS_W-1:0]       i_propellant_mass_kg,
    input  logic                              i_q_ready,
    output logic                              o_push,
    output seci_pkg::t_item                   o_item
);

    logic [seci_pkg::MASS_W-1:0] r_low_thr;
    logic [seci_pkg::MASS_W-1:0] r_dep_thr;
    logic [seci_pkg::SW_W-1:0]   w_sw;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr <= seci_pkg::LOW_LEVEL_RESET;
            r_dep_thr <= seci_pkg::DEPLETION_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                seci_pkg::REG_LOW_LEVEL: r_low_thr <= i_cfg_data;
                seci_pkg::REG_DEPLETION: r_dep_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Switch bit 3i+j: engine's own flag, or its simulate bit on the ground
    for (genvar b = 0; b < seci_pkg::SW_W; b++) begin : g_sw
        assign w_sw[b] = i_engine_thrust_ok[b / 3]
                       | (i_umbilical_connected & i_thrust_ok_simulate[b]);
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid & i_q_ready;

    always_comb begin
        o_item           = '0;
        o_item.is_cmd    = (i_req_type == seci_pkg::REQ_COMMAND);
        if (o_item.is_cmd) begin
            o_item.latch_set = seci_pkg::decode_channel(i_selector_channel);
        end else begin
            o_item.sw        = w_sw;
            o_item.umb       = i_umbilical_connected;
            o_item.level_dry = i_propellant_mass_kg < r_low_thr;
            o_item.dep_trip  = i_propellant_mass_kg < r_dep_thr;
        end
    end

endmodule

/* sv/seci_queue.sv */
// ----------------------------------------------------------------------------
// seci_queue: short item queue
// Decouples the front from the back so each side can stall on its own.
// ----------------------------------------------------------------------------
module seci_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  seci_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output seci_pkg::t_item o_item,
    input  logic            i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    seci_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

/* sv/seci_back.sv */
// ----------------------------------------------------------------------------
// seci_back: relay evaluation and result register
// Holds the latches and relays and evaluates one item per cycle unless a held
// result is not taken; the result stays in the output register until taken.
// ----------------------------------------------------------------------------
module seci_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  seci_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    output seci_pkg::t_result o_result,
    input  logic              i_ready
);

    logic                           r_out_valid;
    seci_pkg::t_result              r_out;
    seci_pkg::t_latch               r_latch;
    logic [1:0]                     r_lvl_inh;
    logic [1:0]                     r_dep_inh;
    logic                           r_sticky;
    logic [seci_pkg::NUM_ENG-1:0]   r_ecr;

    seci_pkg::t_latch               n_latch;
    logic [1:0]                     n_lvl_inh;
    logic [1:0]                     n_dep_inh;
    logic                           n_sticky;
    logic [seci_pkg::NUM_ENG-1:0]   n_ecr;
    seci_pkg::t_result              n_out;

    assign o_pop    = i_valid & (~r_out_valid | i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        logic pls_en, fuel_en, low_lvl, me_inh, se_inh, sef_inh, ob_relay, arm, sok;
        n_latch   = r_latch;
        n_lvl_inh = r_lvl_inh;
        n_dep_inh = r_dep_inh;
        n_sticky  = r_sticky;
        n_ecr     = r_ecr;
        n_out     = '0;
        pls_en    = r_latch[seci_pkg::LB_PLS];
        fuel_en   = r_latch[seci_pkg::LB_FUEL];
        low_lvl   = 1'b0;
        me_inh    = 1'b0;
        se_inh    = 1'b0;
        sef_inh   = 1'b0;
        ob_relay  = 1'b0;
        arm       = 1'b0;
        sok       = 1'b0;
        if (i_item.is_cmd) begin
            n_latch = r_latch | i_item.latch_set;
        end else begin
            // Level sensors and their sticky inhibits
            n_lvl_inh[0] = r_lvl_inh[0] | (~pls_en & i_item.level_dry);
            n_lvl_inh[1] = r_lvl_inh[1] | (~pls_en & i_item.level_dry);
            low_lvl = pls_en & i_item.level_dry & (~n_lvl_inh[0] | ~n_lvl_inh[1]);

            me_inh  = ~r_latch[seci_pkg::LB_ME1] & ~r_latch[seci_pkg::LB_ME2];
            se_inh  = ~r_latch[seci_pkg::LB_SE] & ~i_item.umb;
            sef_inh = (r_ecr != '0) & me_inh;

            // Depletion sensors and their sticky inhibits
            n_dep_inh[0] = r_dep_inh[0] | (i_item.dep_trip & ~fuel_en);
            n_dep_inh[1] = r_dep_inh[1] | (i_item.dep_trip & ~fuel_en);

            if (r_latch[seci_pkg::LB_OBCUT]) begin
                ob_relay = 1'b1;
            end else if (fuel_en & i_item.dep_trip & (~n_dep_inh[0] | ~n_dep_inh[1])) begin
                n_sticky = 1'b1;
                ob_relay = 1'b1;
            end

            // Per-engine cutoff relays test flat switch entries 0..7
            for (int i = 0; i < seci_pkg::NUM_ENG; i++) begin
                sok = i_item.sw[i];
                if (i < seci_pkg::NUM_ENG / 2) begin
                    arm = ~sef_inh & (~me_inh | ~se_inh);
                end else begin
                    arm = ~sef_inh & ~se_inh;
                end
                if ((arm | r_ecr[i]) & ~sok) begin
                    n_ecr[i] = 1'b1;
                end else if ((i < seci_pkg::NUM_ENG / 2) & r_latch[seci_pkg::LB_LOX]
                             & ob_relay) begin
                    n_sticky = 1'b1;
                    n_ecr[i] = 1'b1;
                end else if ((i >= seci_pkg::NUM_ENG / 2) & pls_en
                             & r_latch[seci_pkg::LB_IBCUT]) begin
                    n_ecr[i] = 1'b1;
                end else begin
                    n_ecr[i] = 1'b0;
                end
            end

            n_out.cutoff_command_mask  = i_item.umb ? '0 : n_ecr;
            n_out.thrust_ok_switches   = i_item.sw;
            n_out.low_level_dry        = low_lvl;
            n_out.outboard_cutoff_flag = n_sticky;
            n_out.separation_fire      = r_latch[seci_pkg::LB_SEP];
            n_out.retro_fire           = low_lvl & r_latch[seci_pkg::LB_SEP];
            n_out.outboard_engine_out  = (i_item.sw[3:0] != 4'hF);
            n_out.inboard_engine_out   = (i_item.sw[7:4] != 4'hF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_latch     <= '0;
            r_lvl_inh   <= '0;
            r_dep_inh   <= '0;
            r_sticky    <= 1'b0;
            r_ecr       <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
                r_latch     <= n_latch;
                r_lvl_inh   <= n_lvl_inh;
                r_dep_inh   <= n_dep_inh;
                r_sticky    <= n_sticky;
                r_ecr       <= n_ecr;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_sticky_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sticky |=> r_sticky)
        else $error("outboard cutoff flag dropped");

    a_latches_only_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> ((r_latch & $past(r_latch)) == $past(r_latch)))
        else $error("command latch cleared");

    a_inhibit_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lvl_inh[0] == r_lvl_inh[1]) && (r_dep_inh[0] == r_dep_inh[1]))
        else $error("inhibit relay pair disagrees");

    a_retro_needs_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.retro_fire)
            |-> (r_out.low_level_dry && r_out.separation_fire))
        else $error("retro fire without low level and separation");

    a_pop_on_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_pop)
        else $error("result overwritten while stalled");

endmodule

/* sv/stage_engine_cutoff_interlock.sv */
// ----------------------------------------------------------------------------
// stage_engine_cutoff_interlock: eight-engine stage cutoff relay interlock
// Command transfers set enable and cutoff latches; tick transfers evaluate
// the sensor, inhibit and per-engine cutoff relays and report the result.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transfer. tuser is the kind (0 tick,
//   1 switch selector command); tdata packs the channel and tick fields.
//   m_axis returns exactly one result per accepted item, in order. A command
//   returns an all-zero result; a tick returns the cutoff mask and flags.
//   The cfg channel writes the two mass thresholds (index 0 low level,
//   index 1 depletion); other indexes are ignored. Write it only while idle.
// Path: an item accepted on s_axis passes front classification, a queue
//   write, then back evaluation into the output register before it can
//   appear on m_axis.
// Throughput: one item per cycle unless m_axis_tready stalls the output,
//   set by the back relay evaluation, closing the relay state loop each cycle.
// Reset: synchronous, active low; clears latches, relays, queue and output
//   valid and reloads the default thresholds (24000 kg and 4212 kg).
// Stall: when m_axis_tready is low the result holds in the output register,
//   the queue fills, and s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
module stage_engine_cutoff_interlock #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [seci_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [seci_pkg::MASS_W-1:0]         i_cfg_data,
    // Input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: selector_channel[6:0], engine_thrust_ok[14:7],
    //        thrust_ok_simulate[38:15], umbilical_connected[39],
    //        propellant_mass_kg[58:40], zero fill [63:59]
    input  logic [seci_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // tuser: req_type[0]
    input  logic                                s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: cutoff_command_mask[7:0], thrust_ok_switches[31:8],
    //        low_level_dry[32], outboard_cutoff_flag[33], separation_fire[34],
    //        retro_fire[35], outboard_engine_out[36], inboard_engine_out[37],
    //        zero fill [39:38]
    output logic [seci_pkg::M_TDATA_W-1:0]      m_axis_tdata
);

    seci_pkg::t_item   w_front_item;
    seci_pkg::t_item   w_q_item;
    seci_pkg::t_result w_result;
    logic              w_push;
    logic              w_q_ready;
    logic              w_q_valid;
    logic              w_pop;

    // Classify each transfer and compare mass against the thresholds
    seci_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_cfg_ready           (o_cfg_ready),
        .i_valid               (s_axis_tvalid),
        .o_ready               (s_axis_tready),
        .i_req_type            (s_axis_tuser),
        .i_selector_channel    (s_axis_tdata[6:0]),
        .i_engine_thrust_ok    (s_axis_tdata[14:7]),
        .i_thrust_ok_simulate  (s_axis_tdata[38:15]),
        .i_umbilical_connected (s_axis_tdata[39]),
        .i_propellant_mass_kg  (s_axis_tdata[58:40]),
        .i_q_ready             (w_q_ready),
        .o_push                (w_push),
        .o_item                (w_front_item)
    );

    // Hold classified items until the back can take them
    seci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    // Advance the relay state and register one result per item
    seci_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_item   (w_q_item),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .o_result (w_result),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {(seci_pkg::M_TDATA_W - seci_pkg::RESULT_W)'(0), w_result};

endmodule
